[design/light_attenuated_radiance_macros.svh]
// Assertion macros shared by the light attenuation checker
`ifndef LIGHT_ATTENUATED_RADIANCE_MACROS_SVH
`define LIGHT_ATTENUATED_RADIANCE_MACROS_SVH

// property checked outside reset
`define LAR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked at every edge, reset included
`define LAR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[design/lar_pkg.sv]
// Package: types, widths and constants of the light attenuation pipeline
`timescale 1ns / 1ps
package lar_pkg;

   // pipeline shape
   localparam int FD_STEPS   = 16;  // quotient bits of 2^32 / S
   localparam int CD_STEPS   = 20;  // quotient bits of 4*dot / len
   localparam int SQ_STEPS   = 31;  // root bits of |w|^2
   localparam int NORM_STEPS = 5;   // left normalize stages 16,8,4,2,1
   localparam int PRE_F      = 3;
   localparam int PRE_C      = 10;
   localparam int POST       = 3;
   localparam int LAT        = PRE_C + SQ_STEPS + CD_STEPS + POST;
   localparam int F_DLY      = PRE_C + SQ_STEPS + CD_STEPS - PRE_F - FD_STEPS;
   localparam int OK_DLY     = SQ_STEPS + CD_STEPS;

   // divider cell widths
   localparam int DIV_W    = 41;
   localparam int DIV_LO_W = 20;
   localparam int DIV_Q_W  = 20;

   // square root cell widths
   localparam int SQ_RAD_W  = 62;
   localparam int SQ_ROOT_W = 31;
   localparam int SQ_REM_W  = 34;

   localparam logic [40:0] SUM_CAP = 41'h100_0000_0000;
   localparam logic [40:0] UNITY   = 41'd65536;
   localparam logic [23:0] OUT_MAX = 24'hFF_FFFF;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KIND   = 3'd0,
      CSR_CONST  = 3'd1,
      CSR_LINEAR = 3'd2,
      CSR_QUAD   = 3'd3,
      CSR_RGB    = 3'd4,
      CSR_NORMAL = 3'd5,
      CSR_AREA   = 3'd6
   } csr_type;

   typedef struct packed {
      logic        [31:0] ray_length;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
   } req_type;

   typedef struct packed {
      logic [23:0] radiance_red;
      logic [23:0] radiance_green;
      logic [23:0] radiance_blue;
   } rsp_type;

   typedef struct packed {
      logic [DIV_W-1:0]    rem;
      logic [DIV_W-1:0]    den;
      logic [DIV_LO_W-1:0] lo;
      logic [DIV_Q_W-1:0]  quo;
   } div_type;

   typedef struct packed {
      logic [SQ_REM_W-1:0]  rem;
      logic [SQ_ROOT_W-1:0] root;
      logic [SQ_RAD_W-1:0]  rad;
   } sqrt_type;

endpackage

[design/light_attenuated_radiance.sv]
// Top level: quadratic distance light attenuation, one shadow ray per cycle
//
// Usage
//  - Request: drive req_data and raise start; a transaction is taken at each
//    rising edge with start high and busy low. busy is high only in reset, so
//    a new ray can enter every cycle.
//  - Response: rsp_valid pulses for one cycle with rsp_data; the receiver
//    cannot stall, so each result must be taken in that cycle.
//  - Throughput: one ray per cycle while busy is low; the pipeline depth
//    comes from the chain of 31 square root cells plus 20 divider cells of
//    the cosine path, between the input and output stages.
//  - Config: csr_we/csr_idx/csr_wdata write one register per cycle; write
//    only when no ray is in flight. Unused indexes are ignored.
//  - Reset: synchronous; clears all in-flight transactions and restores the
//    register defaults (constant term 1.0, point light).
//  - Point mode: rgb * F. Area mode: rgb * F * cos * area, saturated.
`timescale 1ns / 1ps
module light_attenuated_radiance import lar_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---------------- configuration registers ----------------
   logic        kind_ff;
   logic [23:0] cc_ff, cl_ff, cq_ff;
   logic [47:0] rgb_ff, nrm_ff;
   logic [31:0] area_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 1'b0;
         cc_ff   <= 24'd65536;
         cl_ff   <= '0;
         cq_ff   <= '0;
         rgb_ff  <= '0;
         nrm_ff  <= '0;
         area_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_type'(csr_idx))
            CSR_KIND:   kind_ff <= csr_wdata[0];
            CSR_CONST:  cc_ff   <= csr_wdata[23:0];
            CSR_LINEAR: cl_ff   <= csr_wdata[23:0];
            CSR_QUAD:   cq_ff   <= csr_wdata[23:0];
            CSR_RGB:    rgb_ff  <= csr_wdata;
            CSR_NORMAL: nrm_ff  <= csr_wdata;
            CSR_AREA:   area_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // ---------------- handshake and valid line ----------------
   logic           accept;
   logic [LAT-1:0] vld_ff;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // ---------------- stage 1: d*d, l*d, p-q ----------------
   logic        [31:0] pst [3];
   logic        [31:0] pen [3];
   logic        [55:0] lin_in;
   logic        [63:0] dd_ff;
   logic        [39:0] lin1_ff;
   logic signed [32:0] vd_ff [3];

   always_comb begin
      pst[0] = req_data.start_x;
      pst[1] = req_data.start_y;
      pst[2] = req_data.start_z;
      pen[0] = req_data.end_x;
      pen[1] = req_data.end_y;
      pen[2] = req_data.end_z;
      lin_in = 56'(cl_ff) * 56'(req_data.ray_length);
   end

   always_ff @(posedge clock) begin
      dd_ff   <= 64'(req_data.ray_length) * 64'(req_data.ray_length);
      lin1_ff <= lin_in[55:16];
      for (int i = 0; i < 3; i++) begin
         vd_ff[i] <= {pst[i][31], pst[i]} - {pen[i][31], pen[i]};
      end
   end

   // ---------------- stage 2: q*dd split, magnitudes ----------------
   logic [47:0] ph_ff, pl_ff;
   logic [39:0] lin2_ff;
   logic [32:0] mag2_ff [3];
   logic        neg2_ff [3];

   always_ff @(posedge clock) begin
      ph_ff   <= 48'(cq_ff) * 48'(dd_ff[63:40]);
      pl_ff   <= 48'(cq_ff) * 48'(dd_ff[39:16]);
      lin2_ff <= lin1_ff;
      for (int i = 0; i < 3; i++) begin
         neg2_ff[i] <= vd_ff[i][32];
         mag2_ff[i] <= vd_ff[i][32] ? (~vd_ff[i] + 33'd1) : vd_ff[i];
      end
   end

   // ---------------- stage 3: attenuation sum, right normalize ----------------
   logic [71:0] prod_in;
   logic [55:0] quad_in;
   logic [40:0] quadc_in;
   logic [41:0] sum_in;
   logic [40:0] sumc_in;
   logic [32:0] mmax_in;
   logic [1:0]  rsh_in;
   logic [32:0] rs_mag_in [3];
   logic [32:0] rs_m_in;
   logic [40:0] fs_ff;
   logic        unity3_ff;

   // left normalize chain; index 0 holds stage 3
   logic [29:0] nsh_ff [NORM_STEPS+1][3];
   logic [29:0] msh_ff [NORM_STEPS+1];
   logic        negsh_ff [NORM_STEPS+1][3];
   logic        nzsh_ff [NORM_STEPS+1];

   always_comb begin
      prod_in  = {ph_ff, 24'd0} + {24'd0, pl_ff};
      quad_in  = prod_in[71:16];
      quadc_in = (quad_in > 56'(SUM_CAP)) ? SUM_CAP : quad_in[40:0];
      sum_in   = 42'(cc_ff) + 42'(lin2_ff) + 42'(quadc_in);
      sumc_in  = (sum_in > 42'(SUM_CAP)) ? SUM_CAP : sum_in[40:0];

      mmax_in = mag2_ff[0];
      if (mag2_ff[1] > mmax_in) mmax_in = mag2_ff[1];
      if (mag2_ff[2] > mmax_in) mmax_in = mag2_ff[2];
      // bring the largest magnitude below 2^30
      if (mmax_in[32])      rsh_in = 2'd3;
      else if (mmax_in[31]) rsh_in = 2'd2;
      else if (mmax_in[30]) rsh_in = 2'd1;
      else                  rsh_in = 2'd0;
      for (int i = 0; i < 3; i++) begin
         rs_mag_in[i] = mag2_ff[i] >> rsh_in;
      end
      rs_m_in = mmax_in >> rsh_in;
   end

   always_ff @(posedge clock) begin
      fs_ff     <= sumc_in;
      unity3_ff <= (sumc_in <= UNITY);
      msh_ff[0] <= rs_m_in[29:0];
      nzsh_ff[0] <= (mmax_in != 33'd0);
      for (int i = 0; i < 3; i++) begin
         nsh_ff[0][i]   <= rs_mag_in[i][29:0];
         negsh_ff[0][i] <= neg2_ff[i];
      end
   end

   // ---------------- stages 4..8: left normalize by 16,8,4,2,1 ----------------
   for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
      localparam int SH = 1 << (NORM_STEPS - 1 - j);
      logic lift;
      assign lift = (msh_ff[j] < (30'd1 << (30 - SH)));
      always_ff @(posedge clock) begin
         msh_ff[j+1]  <= lift ? (msh_ff[j] << SH) : msh_ff[j];
         nzsh_ff[j+1] <= nzsh_ff[j];
         for (int i = 0; i < 3; i++) begin
            nsh_ff[j+1][i]   <= lift ? (nsh_ff[j][i] << SH) : nsh_ff[j][i];
            negsh_ff[j+1][i] <= negsh_ff[j][i];
         end
      end
   end

   // ---------------- stage 9: n*w and w*w ----------------
   logic signed [15:0] nrm_in [3];
   logic signed [30:0] w_in [3];
   logic signed [46:0] dp_ff [3];
   logic        [59:0] sqp_ff [3];
   logic               nz9_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nrm_in[i] = nrm_ff[47-16*i -: 16];
         w_in[i]   = negsh_ff[NORM_STEPS][i] ? -$signed({1'b0, nsh_ff[NORM_STEPS][i]})
                                             : $signed({1'b0, nsh_ff[NORM_STEPS][i]});
      end
   end

   always_ff @(posedge clock) begin
      nz9_ff <= nzsh_ff[NORM_STEPS];
      for (int i = 0; i < 3; i++) begin
         dp_ff[i]  <= 47'(nrm_in[i]) * 47'(w_in[i]);
         sqp_ff[i] <= 60'(nsh_ff[NORM_STEPS][i]) * 60'(nsh_ff[NORM_STEPS][i]);
      end
   end

   // ---------------- stage 10: dot and squared length ----------------
   logic signed [48:0] dot_in;
   logic        [46:0] dot10_ff;
   logic        [61:0] sq10_ff;
   logic               ok10_ff;

   assign dot_in = 49'(dp_ff[0]) + 49'(dp_ff[1]) + 49'(dp_ff[2]);

   always_ff @(posedge clock) begin
      dot10_ff <= dot_in[46:0];
      ok10_ff  <= nz9_ff && (dot_in > 49'sd0);
      sq10_ff  <= 62'(sqp_ff[0]) + 62'(sqp_ff[1]) + 62'(sqp_ff[2]);
   end

   // ---------------- factor divider chain: 2^32 / S ----------------
   div_type    fd_chain [FD_STEPS+1];
   logic       ud_ff [FD_STEPS];
   logic [16:0] f_in;
   logic [16:0] fdl_ff [F_DLY];

   assign fd_chain[0] = '{rem: UNITY, den: fs_ff, lo: '0, quo: '0};

   for (genvar k = 0; k < FD_STEPS; k++) begin : g_fdiv
      lar_div_cell u_cell (.clock(clock), .cur(fd_chain[k]), .nxt(fd_chain[k+1]));
   end

   assign f_in = ud_ff[FD_STEPS-1] ? UNITY[16:0] : {1'b0, fd_chain[FD_STEPS].quo[15:0]};

   always_ff @(posedge clock) begin
      ud_ff[0]  <= unity3_ff;
      fdl_ff[0] <= f_in;
      for (int k = 1; k < FD_STEPS; k++) ud_ff[k] <= ud_ff[k-1];
      for (int k = 1; k < F_DLY; k++) fdl_ff[k] <= fdl_ff[k-1];
   end

   // ---------------- square root chain: len = isqrt(|w|^2) ----------------
   sqrt_type    sq_chain [SQ_STEPS+1];
   logic [46:0] dotd_ff [SQ_STEPS];
   logic        okd_ff [OK_DLY];

   assign sq_chain[0] = '{rem: '0, root: '0, rad: sq10_ff};

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      lar_sqrt_cell u_cell (.clock(clock), .cur(sq_chain[k]), .nxt(sq_chain[k+1]));
   end

   always_ff @(posedge clock) begin
      dotd_ff[0] <= dot10_ff;
      okd_ff[0]  <= ok10_ff;
      for (int k = 1; k < SQ_STEPS; k++) dotd_ff[k] <= dotd_ff[k-1];
      for (int k = 1; k < OK_DLY; k++) okd_ff[k] <= okd_ff[k-1];
   end

   // ---------------- cosine divider chain: 4*dot / len ----------------
   div_type cd_chain [CD_STEPS+1];
   logic [46:0] dotl_in;

   assign dotl_in = dotd_ff[SQ_STEPS-1];
   // numerator 4*dot: the top part seeds the remainder, the low 20 bits shift in
   assign cd_chain[0] = '{rem: DIV_W'(dotl_in[46:18]),
                          den: DIV_W'(sq_chain[SQ_STEPS].root),
                          lo:  {dotl_in[17:0], 2'b00},
                          quo: '0};

   for (genvar k = 0; k < CD_STEPS; k++) begin : g_cdiv
      lar_div_cell u_cell (.clock(clock), .cur(cd_chain[k]), .nxt(cd_chain[k+1]));
   end

   // ---------------- output stages ----------------
   logic [31:0] t1_in [3];
   logic [15:0] t1_ff [3];
   logic [15:0] t1b_ff [3];
   logic [19:0] cos_ff;
   logic [35:0] t2_in [3];
   logic [19:0] t2_ff [3];
   logic [51:0] t3_in [3];
   logic [23:0] out_in [3];
   rsp_type     rsp_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t1_in[i] = 32'(rgb_ff[47-16*i -: 16]) * 32'(fdl_ff[F_DLY-1]);
         t2_in[i] = 36'(t1_ff[i]) * 36'(cos_ff);
         t3_in[i] = 52'(t2_ff[i]) * 52'(area_ff);
         if (!kind_ff) begin
            out_in[i] = 24'(t1b_ff[i]);
         end else if (t3_in[i][51:40] != 12'd0) begin
            out_in[i] = OUT_MAX;
         end else begin
            out_in[i] = t3_in[i][39:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      cos_ff <= okd_ff[OK_DLY-1] ? cd_chain[CD_STEPS].quo : '0;
      for (int i = 0; i < 3; i++) begin
         t1_ff[i]  <= t1_in[i][31:16];
         t1b_ff[i] <= t1_ff[i];
         t2_ff[i]  <= t2_in[i][35:16];
      end
      rsp_ff <= '{radiance_red: out_in[0], radiance_green: out_in[1],
                  radiance_blue: out_in[2]};
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_data  = rsp_ff;

endmodule

[design/lar_div_cell.sv]
// One restoring division step: one quotient bit per cell, registered
`timescale 1ns / 1ps
module lar_div_cell import lar_pkg::*; (
   input  logic    clock,
   input  div_type cur,
   output div_type nxt
);

   logic [DIV_W:0]   acc;
   logic [DIV_W:0]   diff;
   logic             take;
   div_type          cell_in;
   div_type          cell_ff;

   always_comb begin
      acc  = {cur.rem, cur.lo[DIV_LO_W-1]};
      diff = acc - {1'b0, cur.den};
      take = (acc >= {1'b0, cur.den});
      cell_in.den = cur.den;
      cell_in.lo  = {cur.lo[DIV_LO_W-2:0], 1'b0};
      cell_in.quo = {cur.quo[DIV_Q_W-2:0], take};
      cell_in.rem = take ? diff[DIV_W-1:0] : acc[DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign nxt = cell_ff;

endmodule

[design/lar_sqrt_cell.sv]
// One digit-by-digit square root step: one root bit per cell, registered
`timescale 1ns / 1ps
module lar_sqrt_cell import lar_pkg::*; (
   input  logic     clock,
   input  sqrt_type cur,
   output sqrt_type nxt
);

   logic [SQ_REM_W+1:0] acc;
   logic [SQ_REM_W+1:0] trial;
   logic [SQ_REM_W+1:0] diff;
   logic                take;
   sqrt_type            cell_in;
   sqrt_type            cell_ff;

   always_comb begin
      acc   = {cur.rem, cur.rad[SQ_RAD_W-1 -: 2]};
      trial = {{(SQ_REM_W-SQ_ROOT_W){1'b0}}, cur.root, 2'b01};
      diff  = acc - trial;
      take  = (acc >= trial);
      cell_in.rad  = {cur.rad[SQ_RAD_W-3:0], 2'b00};
      cell_in.root = {cur.root[SQ_ROOT_W-2:0], take};
      cell_in.rem  = take ? diff[SQ_REM_W-1:0] : acc[SQ_REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign nxt = cell_ff;

endmodule

[design/lar_checker.sv]
// Port-level checker for the light attenuation pipeline, bound to the top
`timescale 1ns / 1ps
`include "light_attenuated_radiance_macros.svh"
module lar_checker import lar_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   `LAR_ASSERT(a_rsp_has_req, rsp_valid |-> $past(start && !busy, LAT), "response without request")
   `LAR_ASSERT(a_req_gets_rsp, (start && !busy) |-> ##LAT rsp_valid, "request lost")
   `LAR_ASSERT_ALWAYS(a_reset_flush, reset |=> !rsp_valid, "response after reset")

endmodule

bind light_attenuated_radiance lar_checker u_lar_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid)
);

[tb/light_attenuated_radiance_tb.sv]
// Testbench for light_attenuated_radiance: directed and random shadow rays checked against a predictor
`timescale 1ns / 1ps
module light_attenuated_radiance_tb;
   import lar_pkg::*;

   // Cycle limit. The slowest run is about 1700 rays with random sender gaps,
   // plus a drain of the pipe at each of a few dozen register phases. That is
   // far below this limit, so the limit leaves a wide margin.
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_RAYS = 1600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_idx = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   light_attenuated_radiance uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Predictor's own copy of the light registers
   logic        lt_area_mode;
   logic [23:0] lt_const, lt_linear, lt_quad;
   logic [47:0] lt_rgb, lt_normal;
   logic [31:0] lt_area;

   rsp_type radiance_q[$];   // expected radiance, oldest first
   int errors = 0;
   int rays_sent = 0;
   int rays_checked = 0;
   int area_rays = 0;
   int cycles = 0;
   int burst_left = 0;
   bit steady = 1'b0;        // no sender gaps while set

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------
   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] cand;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= x) root = cand;
      end
      return root;
   endfunction

   // Q1.16 attenuation factor from the ray length
   function automatic logic [63:0] distance_falloff(logic [31:0] d);
      logic [63:0]  lin, dd, quad, sum;
      logic [127:0] qprod;
      lin = (64'(lt_linear) * 64'(d)) >> 16;
      dd = (64'(d) * 64'(d)) >> 16;
      qprod = 128'(lt_quad) * 128'(dd);
      quad = (qprod >> 16) > 128'(SUM_CAP) ? 64'(SUM_CAP) : 64'(qprod >> 16);
      if (lin > 64'(SUM_CAP)) lin = 64'(SUM_CAP);
      sum = 64'(lt_const) + lin + quad;
      if (sum > 64'(SUM_CAP)) sum = 64'(SUM_CAP);
      if (sum <= 64'd65536) return 64'd65536;
      return (64'd1 << 32) / sum;
   endfunction

   // Q.16 cosine between the normal and p - q
   function automatic logic [63:0] facing_cosine(req_type r);
      logic signed [63:0] v[3];
      logic [63:0] mag[3];
      logic        neg[3];
      logic [63:0] big, sq, len;
      logic signed [63:0] dot, w, n;
      v[0] = 64'(r.start_x) - 64'(r.end_x);
      v[1] = 64'(r.start_y) - 64'(r.end_y);
      v[2] = 64'(r.start_z) - 64'(r.end_z);
      big = '0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
         if (mag[i] > big) big = mag[i];
      end
      if (big == 64'd0) return 64'd0;
      // bring the largest magnitude into [2^29, 2^30)
      while (big >= (64'd1 << 30)) begin
         big >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (big < (64'd1 << 29)) begin
         big <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      dot = '0;
      sq = '0;
      for (int i = 0; i < 3; i++) begin
         w = neg[i] ? -$signed(mag[i]) : $signed(mag[i]);
         n = 64'($signed(lt_normal[47 - 16*i -: 16]));
         dot += n * w;
         sq += mag[i] * mag[i];
      end
      if (dot <= 0) return 64'd0;
      len = int_sqrt(sq);
      if (len == 64'd0) return 64'd0;
      return (64'(dot) * 64'd4) / len;
   endfunction

   function automatic rsp_type predict_radiance(req_type r);
      logic [63:0] f, cosf, chan;
      logic [23:0] res[3];
      rsp_type o;
      f = distance_falloff(r.ray_length);
      cosf = lt_area_mode ? facing_cosine(r) : 64'd0;
      for (int i = 0; i < 3; i++) begin
         chan = (64'(lt_rgb[47 - 16*i -: 16]) * f) >> 16;
         if (lt_area_mode) begin
            chan = (chan * cosf) >> 16;
            chan = (chan * 64'(lt_area)) >> 16;
         end
         res[i] = chan > 64'(OUT_MAX) ? OUT_MAX : chan[23:0];
      end
      o.radiance_red = res[0];
      o.radiance_green = res[1];
      o.radiance_blue = res[2];
      return o;
   endfunction

   function automatic void light_defaults();
      lt_area_mode = 1'b0;
      lt_const = 24'd65536;
      lt_linear = '0;
      lt_quad = '0;
      lt_rgb = '0;
      lt_normal = '0;
      lt_area = '0;
   endfunction

   // ---------------------------------------------------------------
   // Result checker: every strobe must match the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         cycles <= cycles + 1;
         if (rsp_valid) begin
            if (radiance_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               errors++;
            end else begin
               want = radiance_q.pop_front();
               rays_checked++;
               for (int i = 0; i < 3; i++)
                  if (rsp_data[71 - 24*i -: 24] !== want[71 - 24*i -: 24]) begin
                     $display("%0t: channel %0d mismatch, expected %h, actual %h",
                              $time, i, want[71 - 24*i -: 24], rsp_data[71 - 24*i -: 24]);
                     errors++;
                  end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, radiance_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------
   // One ray transaction; start stays high across a burst
   task automatic send_ray(req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      radiance_q.push_back(predict_radiance(r));
      rays_sent++;
      if (lt_area_mode) area_rays++;
   endtask

   // Drain the pipe so registers can be written safely
   task automatic wait_idle();
      start <= 1'b0;
      burst_left = 0;
      while (radiance_q.size() != 0) @(posedge clock);
      repeat (LAT / 4) @(posedge clock);
   endtask

   // one write, then the enable is dropped again before the model copy follows
   task automatic write_reg(csr_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_KIND:   lt_area_mode = value[0];
         CSR_CONST:  lt_const = value[23:0];
         CSR_LINEAR: lt_linear = value[23:0];
         CSR_QUAD:   lt_quad = value[23:0];
         CSR_RGB:    lt_rgb = value;
         CSR_NORMAL: lt_normal = value;
         CSR_AREA:   lt_area = value[31:0];
         default: ;
      endcase
   endtask

   task automatic set_light(logic kind, logic [23:0] c, logic [23:0] l, logic [23:0] q,
                            logic [47:0] rgb, logic [47:0] nrm, logic [31:0] area);
      // upper bits filled with random values on purpose: the block must mask them
      write_reg(CSR_KIND, 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFFE | 48'(kind));
      write_reg(CSR_CONST, {24'($urandom), c});
      write_reg(CSR_LINEAR, {24'($urandom), l});
      write_reg(CSR_QUAD, {24'($urandom), q});
      write_reg(CSR_RGB, rgb);
      write_reg(CSR_NORMAL, nrm);
      write_reg(CSR_AREA, {16'($urandom), area});
   endtask

   function automatic req_type ray_of(logic [31:0] d, logic [31:0] px, logic [31:0] py,
                                      logic [31:0] pz, logic [31:0] qx, logic [31:0] qy,
                                      logic [31:0] qz);
      req_type r;
      r.ray_length = d;
      r.start_x = px; r.start_y = py; r.start_z = pz;
      r.end_x = qx; r.end_y = qy; r.end_z = qz;
      return r;
   endfunction

   function automatic logic [31:0] pick_length();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h000F_FFFF);
         2: return $urandom_range(0, 32'h0004_0000);
         default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      endcase
   endfunction

   // Mostly well-formed rays with a real direction, some degenerate or extreme
   function automatic req_type pick_ray();
      req_type r;
      logic [31:0] s;
      r = ray_of(pick_length(), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      case ($urandom_range(0, 9))
         0: begin                        // equal end points
            r.end_x = r.start_x; r.end_y = r.start_y; r.end_z = r.start_z;
         end
         1, 2, 3: begin                  // offsets of assorted scale, shrunk on x and y, grown on z
            s = $urandom_range(0, 20);
            r.end_x = r.start_x + ($signed(32'($urandom_range(0, 2047)) - 1024) >>> s);
            r.end_y = r.start_y + ($signed(32'($urandom_range(0, 2047)) - 1024) >>> s);
            r.end_z = r.start_z + ($signed(32'($urandom_range(0, 2047)) - 1024) << s);
         end
         4: begin                        // single-axis offset
            r.end_y = r.start_y;
            r.end_z = r.start_z;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Normal: unit-ish in a random octant, sometimes raw 16-bit noise
   function automatic logic [47:0] pick_normal();
      logic [15:0] c[3];
      for (int i = 0; i < 3; i++) begin
         c[i] = 16'($urandom_range(0, 16384));
         if ($urandom_range(0, 1)) c[i] = -c[i];
      end
      if ($urandom_range(0, 4) == 0) return {$urandom, 16'($urandom)};
      return {c[0], c[1], c[2]};
   endfunction

   function automatic logic [23:0] pick_coef();
      case ($urandom_range(0, 4))
         0: return 24'd0;
         1: return 24'hFF_FFFF;
         2: return 24'($urandom);
         default: return 24'($urandom_range(0, 24'h04_0000));
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_defaults();
      // reset registers: black diffuse gives zero, then full white at unity falloff
      send_ray(ray_of(0, 0, 0, 0, 0, 0, 0));
      send_ray(ray_of(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
      wait_idle();
      write_reg(CSR_RGB, 48'hFFFF_FFFF_FFFF);
      send_ray(ray_of(32'h0001_0000, 1, 2, 3, 4, 5, 6));
      wait_idle();
   endtask

   task automatic test_point_falloff();
      // zero sum gives unity factor
      set_light(1'b0, 24'd0, 24'd0, 24'd0, 48'hFFFF_8000_0001, 48'h0, 32'h0);
      send_ray(ray_of(0, 0, 0, 0, 0, 0, 0));
      send_ray(ray_of(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
      wait_idle();
      // all coefficients at maximum: a huge sum makes the factor small, zero at the longest ray
      set_light(1'b0, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h0, 32'h0);
      send_ray(ray_of(0, 0, 0, 0, 0, 0, 0));
      send_ray(ray_of(32'h0000_0001, 0, 0, 0, 0, 0, 0));
      send_ray(ray_of(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
      wait_idle();
      // quadratic-only and then linear-only distance terms, each over a constant term of 1.0
      set_light(1'b0, 24'd65536, 24'd0, 24'd65536, 48'h1234_5678_9ABC, 48'h0, 32'h0);
      send_ray(ray_of(32'h0002_0000, 0, 0, 0, 0, 0, 0));
      send_ray(ray_of(32'h0100_0000, 0, 0, 0, 0, 0, 0));
      wait_idle();
      write_reg(CSR_QUAD, 48'd0);
      write_reg(CSR_LINEAR, 48'h00_8000);
      send_ray(ray_of(32'h0004_0000, 0, 0, 0, 0, 0, 0));
      wait_idle();
   endtask

   task automatic test_area_cases();
      set_light(1'b1, 24'd65536, 24'd0, 24'd0, 48'hFFFF_FFFF_FFFF,
                {16'h4000, 16'h0000, 16'h0000}, 32'hFFFF_FFFF);
      // equal end points: cosine is zero
      send_ray(ray_of(0, 32'h7FFF_FFFF, 5, 5, 32'h7FFF_FFFF, 5, 5));
      // facing the normal with huge area: saturates
      send_ray(ray_of(0, 32'h0001_0000, 0, 0, 0, 0, 0));
      // facing away: zero
      send_ray(ray_of(0, 0, 0, 0, 32'h0001_0000, 0, 0));
      // coordinate extremes, largest difference
      send_ray(ray_of(0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0));
      send_ray(ray_of(32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0));
      // tiny difference, left normalize path
      send_ray(ray_of(0, 1, 0, 0, 0, 0, 0));
      wait_idle();
      // normal far from unit length: cosine exceeds one for the facing ray, the opposite ray gives zero
      set_light(1'b1, 24'd0, 24'd0, 24'd0, 48'h1000_1000_1000,
                {16'h7FFF, 16'h7FFF, 16'h7FFF}, 32'h0001_0000);
      send_ray(ray_of(0, 3, 3, 3, 0, 0, 0));
      send_ray(ray_of(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
      wait_idle();
   endtask

   task automatic test_unused_index();
      // index past the register list must change nothing
      csr_we <= 1'b1;
      csr_idx <= 3'd7;
      csr_wdata <= '1;
      @(posedge clock);
      csr_we <= 1'b0;
      send_ray(ray_of(0, 3, 3, 3, 0, 0, 0));
      wait_idle();
   endtask

   task automatic test_random_rays();
      int phase;
      int rays;
      phase = 0;
      rays = 0;
      while (rays < RANDOM_RAYS) begin
         if (phase % 5 == 4)
            set_light(1'($urandom_range(0, 1)), 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                      48'hFFFF_FFFF_FFFF, {$urandom, 16'($urandom)}, 32'hFFFF_FFFF);
         else
            set_light($urandom_range(0, 3) != 0, pick_coef(), pick_coef(), pick_coef(),
                      {$urandom, 16'($urandom)}, pick_normal(),
                      $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 32'h0004_0000)));
         steady = (phase % 3 == 2);
         repeat ($urandom_range(40, 120)) begin
            send_ray(pick_ray());
            rays++;
         end
         wait_idle();
         phase++;
      end
      steady = 1'b0;
   endtask

   initial begin
      light_defaults();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_point_falloff();
      test_area_cases();
      test_unused_index();
      test_random_rays();
      wait_idle();
      repeat (LAT + 10) @(posedge clock);
      $display("Sent %0d shadow rays (%0d with an area light), checked %0d results.",
               rays_sent, area_rays, rays_checked);
      $display("Falloff extremes, zero and huge sums, degenerate rays and saturation were covered.");
      if (errors == 0 && radiance_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, radiance_q.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
